[src/mqct_pkg.sv]
// Shared constants, codes and table word types for the memory quota container table.
package mqct_pkg;

	localparam int ENTRY_COUNT = 64;
	localparam int CHILD_LIMIT = 3;

	localparam int ID_W    = $clog2(ENTRY_COUNT);
	localparam int KID_W   = $clog2(CHILD_LIMIT + 1);
	localparam int QUOTA_W = 21;
	localparam int PAGE_W  = 20;
	localparam int CHILD_W = 7;
	// Wide enough for entry * CHILD_LIMIT + 1 + children.
	localparam int CIDX_W  = ID_W + KID_W + 1;

	typedef enum logic [1:0] {
		CMD_QUERY   = 2'd0,
		CMD_SPLIT   = 2'd1,
		CMD_CHARGE  = 2'd2,
		CMD_RELEASE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NO_SLOT   = 2'd1,
		STAT_ALLOC_ERR = 2'd2,
		STAT_UNDERFLOW = 2'd3
	} status_t;

	// Per-entry accounting: written at the addressed entry.
	typedef struct packed {
		logic [QUOTA_W-1:0] usage;
		logic [KID_W-1:0]   kids;
	} acct_t;

	// Per-entry linkage: written when the entry is created as a child.
	typedef struct packed {
		logic [QUOTA_W-1:0] quota;
		logic [ID_W-1:0]    parent;
	} link_t;

endpackage

[src/mqct_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module mqct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/memory_quota_container_table.sv]
// Top level of the memory quota container table: request intake, table update and result register.
// The block keeps 64 quota containers arranged as a tree, with entry 0 as the
// root. Every request reads the addressed entry, returns its fields as they were
// before the request along with a fit check of amount against the remaining
// quota, and then performs the command: query, split off a child, charge one
// page or release one page. The table lives in two synchronous RAMs: an
// accounting RAM (usage and child count), written back at the addressed entry,
// and a linkage RAM (quota and parent), written only at a newly created child.
// Per-entry valid bits in flip-flops make every entry read as zero right after
// reset, so no clearing pass is needed; a split clears the child's accounting
// valid bit, which gives the new child zero usage and no children in the same
// cycle that the parent is charged. The root's quota is never stored in RAM: it
// is the root_quota register itself, which the configuration channel writes
// and which is always ready. A request first does the registered RAM read, then
// computes the result and writes the entry back. A new request is accepted
// only once the previous one has written back, so no two requests ever touch
// the same entry at the same time. The result sits in an output register; a
// new request is taken while an earlier result waits, and after its RAM read it
// holds until the output register is free.
module memory_quota_container_table
	import mqct_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write channel: root quota.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [QUOTA_W-1:0] root_quota,
	// Request channel.
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [ID_W-1:0]    entry_id,
	input  logic [QUOTA_W-1:0] amount,
	input  logic [PAGE_W-1:0]  page_num,
	// Result channel.
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ID_W-1:0]    parent_id,
	output logic [KID_W-1:0]   child_count,
	output logic [QUOTA_W-1:0] entry_quota,
	output logic [QUOTA_W-1:0] entry_usage,
	output logic               fits,
	output logic               in_use,
	output logic [CHILD_W-1:0] new_child,
	output logic [PAGE_W-1:0]  page_out,
	output logic [1:0]         status
);

	// Configuration register and table-side valid bits.
	logic [QUOTA_W-1:0]     root_quota_q;
	logic [ENTRY_COUNT-1:0] acct_vld_q;
	logic [ENTRY_COUNT-1:0] link_vld_q;
	logic [ENTRY_COUNT-1:0] used_q;

	// Request in flight between the RAM read and the write-back.
	logic               v_s1;
	cmd_t               cmd_s1;
	logic [ID_W-1:0]    id_s1;
	logic [QUOTA_W-1:0] amount_s1;
	logic [PAGE_W-1:0]  page_s1;

	logic  in_fire;
	logic  s1_fire;
	acct_t acct_rd;
	link_t link_rd;

	assign cfg_ready = 1'b1;
	assign in_ready  = !v_s1;
	assign in_fire   = in_valid && in_ready;
	// The item in flight completes once the result register is free or draining.
	assign s1_fire   = v_s1 && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_quota_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			root_quota_q <= root_quota;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= 1'b1;
		end else if (s1_fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1    <= cmd_t'(cmd);
			id_s1     <= entry_id;
			amount_s1 <= amount;
			page_s1   <= page_num;
		end
	end

	// Current view of the addressed entry; entries never written read as zero.
	logic [QUOTA_W-1:0] usage_cur;
	logic [KID_W-1:0]   kids_cur;
	logic [QUOTA_W-1:0] quota_cur;
	logic [ID_W-1:0]    parent_cur;

	always_comb begin
		usage_cur  = acct_vld_q[id_s1] ? acct_rd.usage : '0;
		kids_cur   = acct_vld_q[id_s1] ? acct_rd.kids : '0;
		parent_cur = link_vld_q[id_s1] ? link_rd.parent : '0;
		if (id_s1 == '0) begin
			quota_cur = root_quota_q;
		end else begin
			quota_cur = link_vld_q[id_s1] ? link_rd.quota : '0;
		end
	end

	// Fit check, one bit wider so the sum cannot wrap.
	logic [QUOTA_W:0] fit_sum;
	logic             fits_cur;
	assign fit_sum  = {1'b0, usage_cur} + {1'b0, amount_s1};
	assign fits_cur = fit_sum <= {1'b0, quota_cur};

	// Child slot for a split.
	logic [CIDX_W-1:0] child_idx;
	logic              child_ok;
	assign child_idx = CIDX_W'(id_s1) * CIDX_W'(CHILD_LIMIT) + CIDX_W'(1) + CIDX_W'(kids_cur);
	assign child_ok  = ((KID_W + 1)'(kids_cur) < (KID_W + 1)'(CHILD_LIMIT))
		&& (child_idx < CIDX_W'(ENTRY_COUNT));

	// Saturating usage increment, shared by split and charge.
	logic [QUOTA_W-1:0] inc_amt;
	logic [QUOTA_W:0]   inc_sum;
	logic [QUOTA_W-1:0] inc_sat;
	assign inc_amt = (cmd_s1 == CMD_SPLIT) ? amount_s1 : QUOTA_W'(1);
	assign inc_sum = {1'b0, usage_cur} + {1'b0, inc_amt};
	assign inc_sat = inc_sum[QUOTA_W] ? '1 : inc_sum[QUOTA_W-1:0];

	// Command decode and write-back.
	logic               acct_we;
	acct_t              acct_wd;
	logic               link_we;
	link_t              link_wd;
	logic [ID_W-1:0]    child_id;
	status_t            status_nx;
	logic [CHILD_W-1:0] new_child_nx;
	logic [PAGE_W-1:0]  page_nx;

	assign child_id = child_idx[ID_W-1:0];

	always_comb begin
		acct_we        = 1'b0;
		acct_wd.usage  = usage_cur;
		acct_wd.kids   = kids_cur;
		link_we        = 1'b0;
		link_wd.quota  = amount_s1;
		link_wd.parent = id_s1;
		status_nx      = STAT_OK;
		new_child_nx   = CHILD_W'(ENTRY_COUNT);
		page_nx        = '0;
		case (cmd_s1)
			CMD_QUERY: begin
			end
			CMD_SPLIT: begin
				if (child_ok) begin
					acct_we       = 1'b1;
					acct_wd.usage = inc_sat;
					acct_wd.kids  = kids_cur + KID_W'(1);
					link_we       = 1'b1;
					new_child_nx  = CHILD_W'(child_id);
				end else begin
					status_nx = STAT_NO_SLOT;
				end
			end
			CMD_CHARGE: begin
				if (page_s1 == '0) begin
					status_nx = STAT_ALLOC_ERR;
				end else begin
					acct_we       = 1'b1;
					acct_wd.usage = inc_sat;
					page_nx       = page_s1;
				end
			end
			CMD_RELEASE: begin
				if (usage_cur == '0) begin
					status_nx = STAT_UNDERFLOW;
				end else begin
					acct_we       = 1'b1;
					acct_wd.usage = usage_cur - QUOTA_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	logic acct_wen;
	logic link_wen;
	assign acct_wen = s1_fire && acct_we;
	assign link_wen = s1_fire && link_we;

	mqct_ram #(
		.WIDTH ($bits(acct_t)),
		.DEPTH (ENTRY_COUNT)
	) u_acct_ram (
		.clk   (clk),
		.we    (acct_wen),
		.waddr (id_s1),
		.wdata (acct_wd),
		.re    (in_fire),
		.raddr (entry_id),
		.rdata (acct_rd)
	);

	mqct_ram #(
		.WIDTH ($bits(link_t)),
		.DEPTH (ENTRY_COUNT)
	) u_link_ram (
		.clk   (clk),
		.we    (link_wen),
		.waddr (child_id),
		.wdata (link_wd),
		.re    (in_fire),
		.raddr (entry_id),
		.rdata (link_rd)
	);

	// Valid bits and used marks. A new child's accounting bit is cleared so that
	// it reads as zero usage and no children.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acct_vld_q <= '0;
			link_vld_q <= '0;
			used_q     <= ENTRY_COUNT'(1);
		end else begin
			if (acct_wen) begin
				acct_vld_q[id_s1] <= 1'b1;
			end
			if (link_wen) begin
				acct_vld_q[child_id] <= 1'b0;
				link_vld_q[child_id] <= 1'b1;
				used_q[child_id]     <= 1'b1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_fire) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			parent_id   <= parent_cur;
			child_count <= kids_cur;
			entry_quota <= quota_cur;
			entry_usage <= usage_cur;
			fits        <= fits_cur;
			in_use      <= used_q[id_s1];
			new_child   <= new_child_nx;
			page_out    <= page_nx;
			status      <= status_nx;
		end
	end

	// A request held by a full result register stays in flight.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_valid && !out_ready) |=> v_s1)
		else $error("request in flight lost while the result register was full");

	// A split never writes the parent and the child at the same entry.
	a_child_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		link_wen |-> (acct_wen && child_id != id_s1))
		else $error("split wrote the child at the parent's entry");

	// The root's quota comes from the register only; no child lands on the root.
	a_root_no_link: assert property (@(posedge clk) disable iff (!arst_n)
		!link_vld_q[0] && used_q[0])
		else $error("root entry linkage overwritten");

	// Results only appear after a request has completed.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s1))
		else $error("result produced without a request in flight");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the memory quota container table: directed table, then random requests.
module testbench;
	import mqct_pkg::*;

	// One result as the block reports it, in port order.
	typedef struct packed {
		logic [ID_W-1:0]    parent;
		logic [KID_W-1:0]   kids;
		logic [QUOTA_W-1:0] quota;
		logic [QUOTA_W-1:0] usage;
		logic               fits;
		logic               used;
		logic [CHILD_W-1:0] child;
		logic [PAGE_W-1:0]  page;
		status_t            stat;
	} quota_report_t;

	// One directed request. When typed is set, want holds the result written out by hand.
	typedef struct packed {
		cmd_t               op;
		logic [ID_W-1:0]    id;
		logic [QUOTA_W-1:0] amt;
		logic [PAGE_W-1:0]  pg;
		logic               typed;
		quota_report_t      want;
	} stim_row_t;

	localparam logic [QUOTA_W-1:0] ROOT_MAX = 21'd1048576;
	localparam logic [PAGE_W-1:0]  PAGE_MAX = 20'hFFFFF;
	localparam logic [CHILD_W-1:0] NO_CHILD = CHILD_W'(ENTRY_COUNT);
	localparam quota_report_t UNTYPED = '{0, 0, 0, 0, 0, 0, 0, 0, STAT_OK};

	localparam int RANDOM_PHASES   = 4;
	localparam int PHASE_REQUESTS  = 220;
	// The receiver holds off once, well inside the second random phase.
	localparam int HOLD_OFF_AT     = 330;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int TAIL_CYCLES     = 16;

	localparam int DIRECTED_ROWS = 22;

	// The directed part. Rows with a typed result cover reset contents, the field extremes
	// and the error codes; every other row is checked against the predictor. The root quota
	// is set to ROOT_MAX while this table runs.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		// Root right after reset: only its quota has been loaded.
		'{CMD_QUERY, 0, 0, 0, 1, '{0, 0, ROOT_MAX, 0, 1, 1, NO_CHILD, 0, STAT_OK}},
		// Last entry, never written: nothing fits into a zero quota. A query ignores the page.
		'{CMD_QUERY, 63, ROOT_MAX, PAGE_MAX, 1, '{0, 0, 0, 0, 0, 0, NO_CHILD, 0, STAT_OK}},
		// Releasing from an empty entry underflows and leaves usage at zero.
		'{CMD_RELEASE, 5, 0, 0, 1, '{0, 0, 0, 0, 1, 0, NO_CHILD, 0, STAT_UNDERFLOW}},
		// The allocator handed back page zero, so the charge fails.
		'{CMD_CHARGE, 0, ROOT_MAX, 0, 1, '{0, 0, ROOT_MAX, 0, 1, 1, NO_CHILD, 0, STAT_ALLOC_ERR}},
		'{CMD_CHARGE, 0, ROOT_MAX, PAGE_MAX, 0, UNTYPED},
		// Two large splits drive the root's usage into saturation, and a charge holds it there.
		'{CMD_SPLIT, 0, ROOT_MAX, 0, 0, UNTYPED},
		'{CMD_SPLIT, 0, ROOT_MAX, PAGE_MAX, 0, UNTYPED},
		'{CMD_CHARGE, 0, 0, 1, 0, UNTYPED},
		'{CMD_SPLIT, 0, 0, 0, 0, UNTYPED},
		// The root now has all its children, so this split has no slot.
		'{CMD_SPLIT, 0, 5, 0, 0, UNTYPED},
		// The child index of entry 21 lies past the table.
		'{CMD_SPLIT, 21, 0, 0, 1, '{0, 0, 0, 0, 1, 0, NO_CHILD, 0, STAT_NO_SLOT}},
		// A split from an entry nobody created still works and fills entry 61.
		'{CMD_SPLIT, 20, 21'h0AAAAA, 20'hAAAAA, 0, UNTYPED},
		'{CMD_QUERY, 61, 21'h055555, 20'h55555, 0, UNTYPED},
		'{CMD_RELEASE, 0, 0, 0, 0, UNTYPED},
		'{CMD_QUERY, 1, ROOT_MAX, 0, 0, UNTYPED},
		'{CMD_CHARGE, 63, 1, 20'h80000, 0, UNTYPED},
		'{CMD_RELEASE, 63, 0, 0, 0, UNTYPED},
		'{CMD_RELEASE, 63, 0, 0, 0, UNTYPED},
		'{CMD_SPLIT, 1, 21'h07FFFF, 0, 0, UNTYPED},
		'{CMD_CHARGE, 4, 0, 20'h55555, 0, UNTYPED},
		'{CMD_QUERY, 4, 21'h080000, 0, 0, UNTYPED},
		'{CMD_SPLIT, 63, 7, 0, 0, UNTYPED}
	};

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [QUOTA_W-1:0] root_quota;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         cmd;
	logic [ID_W-1:0]    entry_id;
	logic [QUOTA_W-1:0] amount;
	logic [PAGE_W-1:0]  page_num;
	logic               out_valid;
	logic               out_ready;
	logic [ID_W-1:0]    parent_id;
	logic [KID_W-1:0]   child_count;
	logic [QUOTA_W-1:0] entry_quota;
	logic [QUOTA_W-1:0] entry_usage;
	logic               fits;
	logic               in_use;
	logic [CHILD_W-1:0] new_child;
	logic [PAGE_W-1:0]  page_out;
	logic [1:0]         status;

	// These travel alongside the request payload, so the checker sees the hand-written
	// result of a directed row at the very edge where that row is accepted.
	logic               offer_typed;
	quota_report_t      offer_want;

	// The predictor's own copy of the register and the container table.
	logic [QUOTA_W-1:0] root_setting;
	logic [QUOTA_W-1:0] quota_tab  [ENTRY_COUNT];
	logic [QUOTA_W-1:0] usage_tab  [ENTRY_COUNT];
	logic [ID_W-1:0]    parent_tab [ENTRY_COUNT];
	logic [KID_W-1:0]   kids_tab   [ENTRY_COUNT];
	logic               used_tab   [ENTRY_COUNT];

	quota_report_t pending_reports [$];
	int            reports_seen;
	int            mismatches;
	bit            send_burst;

	memory_quota_container_table uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.root_quota  (root_quota),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.entry_id    (entry_id),
		.amount      (amount),
		.page_num    (page_num),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.parent_id   (parent_id),
		.child_count (child_count),
		.entry_quota (entry_quota),
		.entry_usage (entry_usage),
		.fits        (fits),
		.in_use      (in_use),
		.new_child   (new_child),
		.page_out    (page_out),
		.status      (status)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Usage counters stick at the top of their range instead of wrapping.
	function automatic logic [QUOTA_W-1:0] saturating_add(logic [QUOTA_W-1:0] a,
		logic [QUOTA_W-1:0] b);
		logic [QUOTA_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[QUOTA_W] ? {QUOTA_W{1'b1}} : sum[QUOTA_W-1:0];
	endfunction

	// Works out the result of one request from the table as it stands, then applies the
	// request to the table. The reported fields describe the entry before the update.
	function automatic quota_report_t account_request(cmd_t op, logic [ID_W-1:0] id,
		logic [QUOTA_W-1:0] amt, logic [PAGE_W-1:0] pg);
		quota_report_t rep;
		int unsigned   slot;
		rep.parent = parent_tab[id];
		rep.kids   = kids_tab[id];
		rep.quota  = quota_tab[id];
		rep.usage  = usage_tab[id];
		// One extra bit keeps the sum from wrapping before the comparison.
		rep.fits   = ({1'b0, usage_tab[id]} + {1'b0, amt}) <= {1'b0, quota_tab[id]};
		rep.used   = used_tab[id];
		rep.child  = NO_CHILD;
		rep.page   = '0;
		rep.stat   = STAT_OK;
		case (op)
			CMD_SPLIT: begin
				// Children of entry n sit at 3n+1 .. 3n+3; the quota is not checked.
				slot = id * CHILD_LIMIT + 1 + kids_tab[id];
				if (kids_tab[id] >= CHILD_LIMIT || slot >= ENTRY_COUNT) begin
					rep.stat = STAT_NO_SLOT;
				end else begin
					kids_tab[id]     = kids_tab[id] + 1'b1;
					usage_tab[id]    = saturating_add(usage_tab[id], amt);
					quota_tab[slot]  = amt;
					usage_tab[slot]  = '0;
					parent_tab[slot] = id;
					kids_tab[slot]   = '0;
					used_tab[slot]   = 1'b1;
					rep.child        = slot[CHILD_W-1:0];
				end
			end
			CMD_CHARGE: begin
				if (pg == '0) begin
					rep.stat = STAT_ALLOC_ERR;
				end else begin
					usage_tab[id] = saturating_add(usage_tab[id], QUOTA_W'(1));
					rep.page      = pg;
				end
			end
			CMD_RELEASE: begin
				if (usage_tab[id] == '0) begin
					rep.stat = STAT_UNDERFLOW;
				end else begin
					usage_tab[id] = usage_tab[id] - 1'b1;
				end
			end
			default: begin
			end
		endcase
		return rep;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// All traffic is observed here, in one process, so that a request accepted at the
	// same edge as a result is always accounted for before that result is compared.
	always @(posedge clk) begin : traffic_watch
		quota_report_t want;
		if (cfg_valid && cfg_ready) begin
			root_setting = root_quota;
			quota_tab[0] = root_quota;
		end
		if (in_valid && in_ready) begin
			want = account_request(cmd_t'(cmd), entry_id, amount, page_num);
			pending_reports.push_back(offer_typed ? offer_want : want);
		end
		if (out_valid && out_ready) begin
			reports_seen++;
			if (pending_reports.size() == 0) begin
				$error("result arrived with no request outstanding");
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				compare_field("parent_id", want.parent, parent_id);
				compare_field("child_count", want.kids, child_count);
				compare_field("entry_quota", want.quota, entry_quota);
				compare_field("entry_usage", want.usage, entry_usage);
				compare_field("fits", want.fits, fits);
				compare_field("in_use", want.used, in_use);
				compare_field("new_child", want.child, new_child);
				compare_field("page_out", want.page, page_out);
				compare_field("status", want.stat, status);
			end
		end
	end

	// Offers one request after a random gap and returns at the edge where it is taken.
	// Valid is left high so that back-to-back requests are offered without a gap.
	task automatic offer_request(input cmd_t op, input logic [ID_W-1:0] id,
		input logic [QUOTA_W-1:0] amt, input logic [PAGE_W-1:0] pg, input logic typed,
		input quota_report_t want);
		int gap;
		// Now and then switch between gapped traffic and full-rate bursts.
		if ($urandom_range(0, 23) == 0) begin
			send_burst = !send_burst;
		end
		gap = send_burst ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= op;
		entry_id    <= id;
		amount      <= amt;
		page_num    <= pg;
		offer_typed <= typed;
		offer_want  <= want;
		do @(posedge clk); while (!in_ready);
	endtask

	// Random requests. Half of them aim at entries 0 to 20, the only ones that can still
	// have a child slot, so that splits keep growing the tree until it is full.
	task automatic offer_random(input int count);
		cmd_t               op;
		logic [ID_W-1:0]    id;
		logic [QUOTA_W-1:0] amt;
		logic [PAGE_W-1:0]  pg;
		for (int n = 0; n < count; n++) begin
			op = cmd_t'($urandom_range(0, 3));
			id = ID_W'($urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(0, 63));
			case ($urandom_range(0, 5))
				0: amt = '0;
				1: amt = ROOT_MAX;
				2: amt = QUOTA_W'($urandom_range(0, 16));
				default: amt = QUOTA_W'($urandom_range(0, ROOT_MAX));
			endcase
			// Failed allocations show up about one time in six.
			pg = ($urandom_range(0, 5) == 0) ? '0 : PAGE_W'($urandom_range(1, PAGE_MAX));
			offer_request(op, id, amt, pg, 1'b0, UNTYPED);
		end
	endtask

	// Stops offering and waits until every outstanding result has come back.
	task automatic drain_requests;
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_reports.size() != 0);
	endtask

	// Writes the root quota. Only called while no request is in flight.
	task automatic write_root_quota(input logic [QUOTA_W-1:0] value);
		cfg_valid  <= 1'b1;
		root_quota <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Result side: a random stall before each result, with stretches of none, and one
	// long hold-off while the sender keeps offering, so the block backs up into its input.
	initial begin : result_sink
		int stall;
		bit burst;
		bit held;
		out_ready = 1'b0;
		burst     = 1'b0;
		held      = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 23) == 0) begin
				burst = !burst;
			end
			stall = burst ? 0 : $urandom_range(0, 15);
			if (!held && reports_seen >= HOLD_OFF_AT) begin
				held  = 1'b1;
				stall = HOLD_OFF_CYCLES;
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stimulus
		logic [QUOTA_W-1:0] setting;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		root_quota   = '0;
		in_valid     = 1'b0;
		cmd          = CMD_QUERY;
		entry_id     = '0;
		amount       = '0;
		page_num     = '0;
		offer_typed  = 1'b0;
		offer_want   = UNTYPED;
		send_burst   = 1'b0;
		reports_seen = 0;
		mismatches   = 0;
		// Predictor state after reset: an empty table with only the root marked in use.
		root_setting = '0;
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			quota_tab[i]  = '0;
			usage_tab[i]  = '0;
			parent_tab[i] = '0;
			kids_tab[i]   = '0;
			used_tab[i]   = 1'b0;
		end
		used_tab[0] = 1'b1;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_root_quota(ROOT_MAX);
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			offer_request(directed_rows[r].op, directed_rows[r].id, directed_rows[r].amt,
				directed_rows[r].pg, directed_rows[r].typed, directed_rows[r].want);
		end
		drain_requests();

		// Each random phase runs under its own root quota, zero and ROOT_MAX among them.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: setting = '0;
				1: setting = QUOTA_W'($urandom_range(1, ROOT_MAX - 1));
				2: setting = ROOT_MAX;
				default: setting = QUOTA_W'($urandom_range(0, 4096));
			endcase
			write_root_quota(setting);
			offer_random(PHASE_REQUESTS);
			drain_requests();
		end

		// Give a stray extra result time to show up before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// A hang anywhere, including a result that never comes, ends the run here.
	initial begin : watchdog
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
